[rtl/tjm_pkg.sv]
// Package for the tick jitter monitor: field widths, reset values,
// register indexes and stream packing constants.
// No dependencies.
package tjm_pkg;

  localparam int unsigned TIME_W   = 48;
  localparam int unsigned FRAC_W   = 8;
  localparam int unsigned EXEC_W   = 24;
  localparam int unsigned RATE_W   = 10;
  localparam int unsigned THR_W    = 24;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned MISS_W   = 16;
  localparam int unsigned MTOT_W   = 32;
  localparam int unsigned AVGJ_W   = TIME_W + FRAC_W;
  localparam int unsigned AVGD_W   = EXEC_W + FRAC_W;

  // expected interval: (RATE_NUM div rate) * US_PER_MS, at most 1000000
  localparam int unsigned RATE_NUM  = 1000;
  localparam int unsigned US_PER_MS = 1000;
  localparam int unsigned EXP_W     = 20;

  // moving average: (9*old + sample) div AVG_DEN
  localparam int unsigned AVG_DEN   = 10;
  localparam int unsigned REM_W     = 4;
  localparam int unsigned DIV_W     = AVGJ_W + REM_W;
  localparam int unsigned STEP_W    = $clog2(DIV_W);

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(60);
  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(1000);

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = THR_W;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_JIT_THR   = 1'b1;

  localparam int unsigned IN_FIELDS_W  = TIME_W + EXEC_W;
  localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = CNT_W + TIME_W + 1 + MISS_W + MTOT_W
                                         + AVGJ_W + AVGD_W + EXEC_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

endpackage

[rtl/tick_jitter_monitor_top.sv]
// Tick jitter monitor top level: sequencer with bit-serial dividers.
// Depends on tjm_pkg.
//
// Each accepted tick runs through a ten-step restoring division that finds
// the expected interval from the tick rate, three short wide-add steps, and
// sixty steps of three bit-serial dividers that run side by side (missed
// ticks, and the division by ten of both moving averages). A new tick is
// taken only after the last one's result has moved to the output register.
// A finished result waits in the output register while the next tick is
// already being worked on. A tick rate of zero counts as one; statistics
// survive register writes.
module tick_jitter_monitor_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [tjm_pkg::CFG_IDX_W-1:0]        cfg_addr_i,
  input  logic [tjm_pkg::CFG_W-1:0]            cfg_wdata_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tick_time_us, exec_time_us
  input  logic [tjm_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tick_number, jitter_us, jitter_exceeded, missed_now, missed_sum,
  // jitter_average, duration_average, duration_peak, zero fill
  output logic [tjm_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // jitter_valid
  output logic                                 m_axis_tuser
);

  localparam int unsigned TW  = tjm_pkg::TIME_W;
  localparam int unsigned EW  = tjm_pkg::EXP_W;
  localparam int unsigned DW  = tjm_pkg::DIV_W;
  localparam int unsigned RW  = tjm_pkg::REM_W;
  localparam int unsigned RTW = tjm_pkg::RATE_W;
  localparam int unsigned SW  = tjm_pkg::STEP_W;
  localparam int unsigned PAD_W = tjm_pkg::OUT_TDATA_W - tjm_pkg::OUT_FIELDS_W;

  typedef enum logic [2:0] {
    S_IDLE, S_RATE, S_EXP, S_JIT, S_MIX, S_DIV, S_FIN
  } state_e;

  state_e                       state_q;
  logic [SW-1:0]                step_q;

  logic [RTW-1:0]               rate_q;
  logic [tjm_pkg::THR_W-1:0]    thr_q;

  logic [TW-1:0]                now_q;
  logic [tjm_pkg::EXEC_W-1:0]   exec_q;

  logic [TW-1:0]                prev_q;
  logic [tjm_pkg::CNT_W-1:0]    tick_q;
  logic [tjm_pkg::MTOT_W-1:0]   mtot_q;
  logic [tjm_pkg::AVGJ_W-1:0]   avgj_q;
  logic [tjm_pkg::AVGD_W-1:0]   avgd_q;
  logic [tjm_pkg::EXEC_W-1:0]   peak_q;

  logic [RTW-1:0]               rq_q, rr_q, rdiv_q;
  logic [EW-1:0]                exp_q;
  logic                         meas_q, fwd_q, men_q, exc_q;
  logic [TW-1:0]                fdiff_q, bdiff_q, jit_q;
  logic [DW-1:0]                mq_q, jq_q, dq_q;
  logic [EW-1:0]                mr_q;
  logic [RW-1:0]                jr_q, dr_q;

  logic                         ov_q;
  logic [tjm_pkg::CNT_W-1:0]    o_tick_q;
  logic [TW-1:0]                o_jit_q;
  logic                         o_meas_q, o_exc_q;
  logic [tjm_pkg::MISS_W-1:0]   o_miss_q;
  logic [tjm_pkg::MTOT_W-1:0]   o_mtot_q;
  logic [tjm_pkg::AVGJ_W-1:0]   o_avgj_q;
  logic [tjm_pkg::AVGD_W-1:0]   o_avgd_q;
  logic [tjm_pkg::EXEC_W-1:0]   o_peak_q;

  // rate divider step
  logic [RTW:0]   r_t;
  logic           r_ge;
  logic [RTW-1:0] rr_d;
  logic [EW-1:0]  exp_d;

  // interval
  logic [TW:0]    fdiff_d;
  logic [TW-1:0]  bdiff_d;

  // jitter
  logic [TW-1:0]  e_ext;
  logic [TW:0]    over_d, bsum_d;
  logic [TW-1:0]  jit_d;
  logic           men_d;

  // moving average numerators
  logic [DW-1:0]  nj_d, nd_d;
  logic           exc_d;

  // divider steps
  logic [EW:0]    m_t;
  logic           m_ge;
  logic [EW-1:0]  mr_d;
  logic [RW:0]    j_t, d_t;
  logic           j_ge, d_ge;
  logic [RW-1:0]  jr_d, dr_d;

  // final results
  logic [DW-1:0]               mq_m1;
  logic [tjm_pkg::MISS_W-1:0]  miss_d;
  logic [tjm_pkg::MTOT_W:0]    msum;
  logic [tjm_pkg::MTOT_W-1:0]  mtot_d;
  logic [tjm_pkg::AVGJ_W-1:0]  avgj_d;
  logic [tjm_pkg::EXEC_W-1:0]  peak_d;
  logic                        out_free;

  assign r_t   = {rr_q, rq_q[RTW-1]};
  assign r_ge  = r_t >= {1'b0, rdiv_q};
  assign rr_d  = r_ge ? RTW'(r_t - {1'b0, rdiv_q}) : r_t[RTW-1:0];
  assign exp_d = EW'(rq_q * tjm_pkg::US_PER_MS);

  assign fdiff_d = {1'b0, now_q} - {1'b0, prev_q};
  assign bdiff_d = prev_q - now_q;

  assign e_ext  = TW'(exp_q);
  assign over_d = {1'b0, fdiff_q} - {1'b0, e_ext};
  assign bsum_d = {1'b0, bdiff_q} + {1'b0, e_ext};

  always_comb begin
    if (!meas_q) begin
      jit_d = '0;
    end else if (fwd_q) begin
      jit_d = over_d[TW] ? (e_ext - fdiff_q) : over_d[TW-1:0];
    end else begin
      jit_d = bsum_d[TW] ? '1 : bsum_d[TW-1:0];
    end
  end

  assign men_d = meas_q && fwd_q && (exp_q != '0) && ({1'b0, fdiff_q} > {e_ext, 1'b0});

  assign nj_d = (DW'(avgj_q) << 3) + DW'(avgj_q) + DW'({jit_q, {tjm_pkg::FRAC_W{1'b0}}});
  assign nd_d = (DW'(avgd_q) << 3) + DW'(avgd_q) + DW'({exec_q, {tjm_pkg::FRAC_W{1'b0}}});
  assign exc_d = meas_q && (jit_q > TW'(thr_q));

  assign m_t  = {mr_q, mq_q[DW-1]};
  assign m_ge = m_t >= {1'b0, exp_q};
  assign mr_d = m_ge ? EW'(m_t - {1'b0, exp_q}) : m_t[EW-1:0];

  assign j_t  = {jr_q, jq_q[DW-1]};
  assign j_ge = j_t >= (RW + 1)'(tjm_pkg::AVG_DEN);
  assign jr_d = j_ge ? RW'(j_t - (RW + 1)'(tjm_pkg::AVG_DEN)) : j_t[RW-1:0];

  assign d_t  = {dr_q, dq_q[DW-1]};
  assign d_ge = d_t >= (RW + 1)'(tjm_pkg::AVG_DEN);
  assign dr_d = d_ge ? RW'(d_t - (RW + 1)'(tjm_pkg::AVG_DEN)) : d_t[RW-1:0];

  assign mq_m1 = mq_q - DW'(1);

  always_comb begin
    if (!men_q) begin
      miss_d = '0;
    end else if (|mq_m1[DW-1:tjm_pkg::MISS_W]) begin
      miss_d = '1;
    end else begin
      miss_d = mq_m1[tjm_pkg::MISS_W-1:0];
    end
  end

  assign msum   = {1'b0, mtot_q} + (tjm_pkg::MTOT_W + 1)'(miss_d);
  assign mtot_d = msum[tjm_pkg::MTOT_W] ? '1 : msum[tjm_pkg::MTOT_W-1:0];
  assign avgj_d = meas_q ? jq_q[tjm_pkg::AVGJ_W-1:0] : avgj_q;
  assign peak_d = (exec_q > peak_q) ? exec_q : peak_q;
  assign out_free = !ov_q || m_axis_tready;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = o_meas_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, o_peak_q, o_avgd_q, o_avgj_q, o_mtot_q,
                          o_miss_q, o_exc_q, o_jit_q, o_tick_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= tjm_pkg::RATE_RESET;
      thr_q  <= tjm_pkg::THR_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        tjm_pkg::REG_TICK_RATE: rate_q <= cfg_wdata_i[RTW-1:0];
        tjm_pkg::REG_JIT_THR:   thr_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      prev_q  <= '0;
      tick_q  <= '0;
      mtot_q  <= '0;
      avgj_q  <= '0;
      avgd_q  <= '0;
      peak_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      ov_q <= ((state_q == S_FIN) && out_free) || (ov_q && !m_axis_tready);
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            now_q   <= s_axis_tdata[TW-1:0];
            exec_q  <= s_axis_tdata[tjm_pkg::IN_FIELDS_W-1:TW];
            rq_q    <= RTW'(tjm_pkg::RATE_NUM);
            rr_q    <= '0;
            rdiv_q  <= (rate_q == '0) ? RTW'(1) : rate_q;
            step_q  <= '0;
            state_q <= S_RATE;
          end
        end
        S_RATE: begin
          rr_q <= rr_d;
          rq_q <= {rq_q[RTW-2:0], r_ge};
          if (step_q == SW'(RTW - 1)) begin
            step_q  <= '0;
            state_q <= S_EXP;
          end else begin
            step_q <= step_q + SW'(1);
          end
        end
        S_EXP: begin
          exp_q   <= exp_d;
          meas_q  <= (prev_q != '0);
          fwd_q   <= !fdiff_d[TW];
          fdiff_q <= fdiff_d[TW-1:0];
          bdiff_q <= bdiff_d;
          state_q <= S_JIT;
        end
        S_JIT: begin
          jit_q   <= jit_d;
          men_q   <= men_d;
          state_q <= S_MIX;
        end
        S_MIX: begin
          exc_q   <= exc_d;
          mq_q    <= DW'(fdiff_q);
          mr_q    <= '0;
          jq_q    <= nj_d;
          jr_q    <= '0;
          dq_q    <= nd_d;
          dr_q    <= '0;
          step_q  <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          mr_q <= mr_d;
          mq_q <= {mq_q[DW-2:0], m_ge};
          jr_q <= jr_d;
          jq_q <= {jq_q[DW-2:0], j_ge};
          dr_q <= dr_d;
          dq_q <= {dq_q[DW-2:0], d_ge};
          if (step_q == SW'(DW - 1)) begin
            step_q  <= '0;
            state_q <= S_FIN;
          end else begin
            step_q <= step_q + SW'(1);
          end
        end
        S_FIN: begin
          if (out_free) begin
            prev_q   <= now_q;
            tick_q   <= tick_q + 1'b1;
            mtot_q   <= mtot_d;
            avgj_q   <= avgj_d;
            avgd_q   <= dq_q[tjm_pkg::AVGD_W-1:0];
            peak_q   <= peak_d;
            o_tick_q <= tick_q + 1'b1;
            o_jit_q  <= jit_q;
            o_meas_q <= meas_q;
            o_exc_q  <= exc_q;
            o_miss_q <= miss_d;
            o_mtot_q <= mtot_d;
            o_avgj_q <= avgj_d;
            o_avgd_q <= dq_q[tjm_pkg::AVGD_W-1:0];
            o_peak_q <= peak_d;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a tick is in work");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (step_q <= SW'(DW - 1)))
    else $error("divider step counter out of range");

  a_flags_need_measure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && (o_exc_q || (o_miss_q != '0)) |-> o_meas_q)
    else $error("jitter flag or missed count without a measured interval");

  a_peak_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) && out_free |=> (o_peak_q >= exec_q))
    else $error("duration peak below current execution time");
`endif

endmodule
